### hdl/bsub_pkg.sv
// Shared types and constants for the byte-to-string substitution engine.
package bsub_pkg;

   // Request type codes on the input channel.
   localparam logic [1:0] REQ_CONVERT   = 2'd0;
   localparam logic [1:0] REQ_LOAD_KEY  = 2'd1;
   localparam logic [1:0] REQ_LOAD_CHAR = 2'd2;

   // Carriage return is dropped from the stream.
   localparam logic [7:0] CR_BYTE = 8'd13;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_PASS,
      ST_EMIT
   } state_type;

   // Table port strobes from the sequencer.
   typedef struct packed {
      logic key_wr;
      logic key_rd;
      logic rep_wr;
      logic rep_rd;
   } tbl_ctrl_type;

endpackage

### hdl/bsub_table.sv
// Key/length table and replacement string memory, registered reads.
module bsub_table
   import bsub_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64,
   parameter int MAX_OUT_LEN   = 16,
   parameter int IW  = 6,
   parameter int LW  = 5,
   parameter int RAW = 10
) (
   input  logic               clock,
   input  tbl_ctrl_type       ctrl,
   input  logic [IW-1:0]      key_wr_addr,
   input  logic [8+LW-1:0]    key_wr_data,
   input  logic [IW-1:0]      key_rd_addr,
   output logic [8+LW-1:0]    key_rd_data,
   input  logic [RAW-1:0]     rep_wr_addr,
   input  logic [7:0]         rep_wr_data,
   input  logic [RAW-1:0]     rep_rd_addr,
   output logic [7:0]         rep_rd_data
);

   // {key, length} per entry
   logic [8+LW-1:0] key_mem [TABLE_ENTRIES];
   logic [7:0]      rep_mem [TABLE_ENTRIES*MAX_OUT_LEN];

   logic [8+LW-1:0] key_rd_ff;
   logic [7:0]      rep_rd_ff;

   always_ff @(posedge clock) begin
      if (ctrl.key_wr) begin
         key_mem[key_wr_addr] <= key_wr_data;
      end
      if (ctrl.key_rd) begin
         key_rd_ff <= key_mem[key_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rep_wr) begin
         rep_mem[rep_wr_addr] <= rep_wr_data;
      end
      if (ctrl.rep_rd) begin
         rep_rd_ff <= rep_mem[rep_rd_addr];
      end
   end

   assign key_rd_data = key_rd_ff;
   assign rep_rd_data = rep_rd_ff;

endmodule

### hdl/bsub_seq.sv
// Sequencer: request decode, shared key comparator, emit loop, output register.
module bsub_seq
   import bsub_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64,
   parameter int MAX_OUT_LEN   = 16,
   parameter int IW  = 6,
   parameter int CW  = 7,
   parameter int LW  = 5,
   parameter int RAW = 10
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic [7:0]         req_data_byte,
   input  logic [5:0]         req_entry_index,
   input  logic [3:0]         req_char_pos,
   input  logic [4:0]         req_out_length,
   // search limit, already clamped
   input  logic [CW-1:0]      limit,
   // table side
   output tbl_ctrl_type       ctrl,
   output logic [IW-1:0]      key_wr_addr,
   output logic [8+LW-1:0]    key_wr_data,
   output logic [IW-1:0]      key_rd_addr,
   input  logic [8+LW-1:0]    key_rd_data,
   output logic [RAW-1:0]     rep_wr_addr,
   output logic [7:0]         rep_wr_data,
   output logic [RAW-1:0]     rep_rd_addr,
   input  logic [7:0]         rep_rd_data,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_last,
   output logic [31:0]        rsp_conversion_count
);

   state_type   state_ff, state_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [7:0]    byte_ff, byte_in;
   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] pos_ff, pos_in;
   logic [31:0]   count_ff, count_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic          rsp_last_ff, rsp_last_in;
   logic [31:0]   rsp_count_ff, rsp_count_in;

   logic          out_free;
   logic          out_load;
   logic [CW-1:0] idx_next;
   logic [LW-1:0] pos_next;
   logic [LW-1:0] len_sat;
   logic [7:0]    rd_key;
   logic [LW-1:0] rd_len;
   logic          entry_ok;
   logic          pos_ok;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign idx_next = idx_ff + 1'b1;
   assign pos_next = pos_ff + 1'b1;
   assign rd_key   = key_rd_data[8+LW-1:LW];
   assign rd_len   = key_rd_data[LW-1:0];
   assign entry_ok = int'(req_entry_index) < TABLE_ENTRIES;
   assign pos_ok   = int'(req_char_pos) < MAX_OUT_LEN;
   assign len_sat  = (int'(req_out_length) > MAX_OUT_LEN) ? LW'(MAX_OUT_LEN)
                                                          : LW'(req_out_length);

   assign req_stall   = (state_ff != ST_IDLE);
   assign key_wr_addr = IW'(req_entry_index);
   assign key_wr_data = {req_data_byte, len_sat};
   assign rep_wr_addr = RAW'(req_entry_index) * RAW'(MAX_OUT_LEN) + RAW'(req_char_pos);
   assign rep_wr_data = req_data_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      byte_ff      <= byte_in;
      len_ff       <= len_in;
      pos_ff       <= pos_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_count_ff <= rsp_count_in;
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      byte_in      = byte_ff;
      len_in       = len_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      ctrl         = '0;
      key_rd_addr  = '0;
      rep_rd_addr  = RAW'(idx_ff) * RAW'(MAX_OUT_LEN) + RAW'(pos_ff);
      out_load     = 1'b0;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_count_in = rsp_count_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_type)
                  REQ_LOAD_KEY: begin
                     ctrl.key_wr = entry_ok;
                  end
                  REQ_LOAD_CHAR: begin
                     ctrl.rep_wr = entry_ok && pos_ok;
                  end
                  REQ_CONVERT: begin
                     byte_in = req_data_byte;
                     idx_in  = '0;
                     if (req_data_byte == CR_BYTE) begin
                        state_in = ST_IDLE;
                     end else if (limit == '0) begin
                        state_in = ST_PASS;
                     end else begin
                        ctrl.key_rd = 1'b1;
                        state_in    = ST_SEARCH;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            // entry idx_ff is in the read register; on a miss below the limit the next entry is fetched meanwhile
            if (rd_key == byte_ff) begin
               if (count_ff != '1) begin
                  count_in = count_ff + 1'b1;
               end
               if (rd_len == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  len_in      = rd_len;
                  pos_in      = '0;
                  ctrl.rep_rd = 1'b1;
                  rep_rd_addr = RAW'(idx_ff) * RAW'(MAX_OUT_LEN);
                  state_in    = ST_EMIT;
               end
            end else if (idx_next == limit) begin
               state_in = ST_PASS;
            end else begin
               idx_in      = idx_next;
               ctrl.key_rd = 1'b1;
               key_rd_addr = IW'(idx_next);
            end
         end
         ST_PASS: begin
            if (out_free) begin
               out_load     = 1'b1;
               rsp_byte_in  = byte_ff;
               rsp_last_in  = 1'b1;
               rsp_count_in = count_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_load     = 1'b1;
               rsp_byte_in  = rep_rd_data;
               rsp_last_in  = (pos_next == len_ff);
               rsp_count_in = count_ff;
               if (pos_next == len_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  pos_in      = pos_next;
                  ctrl.rep_rd = 1'b1;
                  rep_rd_addr = RAW'(idx_ff) * RAW'(MAX_OUT_LEN) + RAW'(pos_next);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_out_byte         = rsp_byte_ff;
   assign rsp_last             = rsp_last_ff;
   assign rsp_conversion_count = rsp_count_ff;

endmodule

### hdl/byte_to_string_substituter.sv
// Top level of the byte-to-string substitution engine.
//
// Usage:
//  - Request channel (req_*): valid/stall. req_type selects convert data byte,
//    load key and length for entry_index, or load one replacement byte at
//    char_pos. Loads are written when taken and produce no response.
//  - Response channel (rsp_*): one transaction per emitted byte, rsp_last on
//    the final byte for an input byte, plus the saturating match count.
//  - csr_wr_en/csr_wr_data set entries_used; write only while idle.
//  - A convert searches entries 0..entries_used-1 (entries_used capped at
//    TABLE_ENTRIES) up to the first match, one entry per cycle through the
//    single key comparator, then emits the replacement one byte per cycle
//    from the string memory while the response channel is not stalled; a
//    miss passes the input byte through. Carriage return is dropped.
//  - req_stall is high while a convert is in progress.
//  - A stalled response holds in the output register and the emit loop waits;
//    the next request is taken while the last byte still waits.
//  - Reset (synchronous) clears the counter, entries_used and control state.
//    Table memories are not cleared; entries must be loaded before use.
module byte_to_string_substituter
   import bsub_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64,
   parameter int MAX_OUT_LEN   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_data_byte,
   input  logic [5:0]  req_entry_index,
   input  logic [3:0]  req_char_pos,
   input  logic [4:0]  req_out_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last,
   output logic [31:0] rsp_conversion_count,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);

   // entry index, entry count, length and string memory address widths
   localparam int IW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW  = $clog2(TABLE_ENTRIES + 1);
   localparam int LW  = $clog2(MAX_OUT_LEN + 1);
   localparam int RAW = (TABLE_ENTRIES * MAX_OUT_LEN > 1) ?
                        $clog2(TABLE_ENTRIES * MAX_OUT_LEN) : 1;

   logic [6:0]      entries_used_ff, entries_used_in;
   logic [CW-1:0]   limit;

   tbl_ctrl_type    ctrl;
   logic [IW-1:0]   key_wr_addr;
   logic [8+LW-1:0] key_wr_data;
   logic [IW-1:0]   key_rd_addr;
   logic [8+LW-1:0] key_rd_data;
   logic [RAW-1:0]  rep_wr_addr;
   logic [7:0]      rep_wr_data;
   logic [RAW-1:0]  rep_rd_addr;
   logic [7:0]      rep_rd_data;

   // entries_used register
   assign entries_used_in = csr_wr_en ? csr_wr_data : entries_used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_used_ff <= '0;
      end else begin
         entries_used_ff <= entries_used_in;
      end
   end

   // an oversized setting searches the whole table
   always_comb begin
      if (int'(entries_used_ff) > TABLE_ENTRIES) begin
         limit = CW'(TABLE_ENTRIES);
      end else begin
         limit = CW'(entries_used_ff);
      end
   end

   bsub_seq #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .MAX_OUT_LEN   (MAX_OUT_LEN),
      .IW            (IW),
      .CW            (CW),
      .LW            (LW),
      .RAW           (RAW)
   ) u_seq (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_type             (req_type),
      .req_data_byte        (req_data_byte),
      .req_entry_index      (req_entry_index),
      .req_char_pos         (req_char_pos),
      .req_out_length       (req_out_length),
      .limit                (limit),
      .ctrl                 (ctrl),
      .key_wr_addr          (key_wr_addr),
      .key_wr_data          (key_wr_data),
      .key_rd_addr          (key_rd_addr),
      .key_rd_data          (key_rd_data),
      .rep_wr_addr          (rep_wr_addr),
      .rep_wr_data          (rep_wr_data),
      .rep_rd_addr          (rep_rd_addr),
      .rep_rd_data          (rep_rd_data),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_last             (rsp_last),
      .rsp_conversion_count (rsp_conversion_count)
   );

   bsub_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .MAX_OUT_LEN   (MAX_OUT_LEN),
      .IW            (IW),
      .LW            (LW),
      .RAW           (RAW)
   ) u_table (
      .clock       (clock),
      .ctrl        (ctrl),
      .key_wr_addr (key_wr_addr),
      .key_wr_data (key_wr_data),
      .key_rd_addr (key_rd_addr),
      .key_rd_data (key_rd_data),
      .rep_wr_addr (rep_wr_addr),
      .rep_wr_data (rep_wr_data),
      .rep_rd_addr (rep_rd_addr),
      .rep_rd_data (rep_rd_data)
   );

   // loads and unused request types complete in the cycle they are taken
   a_load_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_type != REQ_CONVERT) |=> !req_stall)
      else $error("load transaction left the engine busy");

   // a byte that is not the last of its string means the emit loop is running
   a_mid_string_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> req_stall)
      else $error("non-final byte pending while idle");

   // the match count in the output stream never goes backward
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(rsp_valid) && !$past(reset)) |->
         (rsp_conversion_count >= $past(rsp_conversion_count)))
      else $error("conversion count decreased");

endmodule
